FILE: rtl/bdtw_pkg.sv
package bdtw_pkg;

	// Register map: index of each register, byte address is 4 * index
	localparam int unsigned ADDR_W    = 3;
	localparam int unsigned REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_DIGIT_ZERO = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_CURRENCY   = 1'b1;

	// Input word: value to show and the column of its units digit
	typedef struct packed {
		logic [31:0] amount;
		logic [7:0]  right_column;
	} in_word_t;

	// Output word: one tile write
	typedef struct packed {
		logic [7:0] tile_column;
		logic [7:0] tile_code;
		logic       is_last;
	} out_word_t;

	// Converter sequencer
	typedef enum logic [1:0] {
		CV_IDLE,
		CV_SHIFT,
		CV_DONE
	} conv_state_t;

	// Emitter sequencer
	typedef enum logic [1:0] {
		EM_IDLE,
		EM_CUR,
		EM_DIG
	} emit_state_t;

endpackage

FILE: rtl/binary_to_decimal_tile_writer.sv
// Channel   Direction  Word                        Handshake
// amt       in         amount, right_column        amt_valid / amt_stall
// tile      out        tile_column, tile_code,     tile_valid / tile_stall
//                      is_last
// apb       in/out     digit_zero_tile, currency   psel / penable / pready
//
// An accepted word passes through the digit chain (one decimal shift step per
// cycle), then hands its digits to the emitter, which writes one tile per cycle
// while the output is not stalled (at most DIGITS + 1 tiles per word). The two
// overlap: the chain converts the next word while the emitter writes this one.
// Reset clears both sequencers, the output valid and the two registers.
// A stalled output holds its word; the emitter then waits, and the chain holds
// its digits and stalls the input until the emitter takes them.
module binary_to_decimal_tile_writer #(
	parameter int unsigned DIGITS     = 9,
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             amt_valid,
	output logic                             amt_stall,
	input  bdtw_pkg::in_word_t               amt_word,
	output logic                             tile_valid,
	input  logic                             tile_stall,
	output bdtw_pkg::out_word_t              tile_word,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bdtw_pkg::ADDR_W-1:0]      paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	logic [7:0]                        digit_zero_q;
	logic [7:0]                        currency_q;
	logic                              cfg_wr;
	logic [bdtw_pkg::REG_IDX_W-1:0]    reg_idx;
	logic                              hand_valid;
	logic                              hand_ready;
	logic [DIGITS-1:0][3:0]            digits;
	logic [7:0]                        right_col;

	// Register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[bdtw_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_zero_q <= 8'd0;
			currency_q   <= 8'd0;
		end else if (cfg_wr) begin
			case (reg_idx)
				bdtw_pkg::REG_DIGIT_ZERO: digit_zero_q <= pwdata[7:0];
				bdtw_pkg::REG_CURRENCY:   currency_q   <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			bdtw_pkg::REG_DIGIT_ZERO: prdata = {24'd0, digit_zero_q};
			bdtw_pkg::REG_CURRENCY:   prdata = {24'd0, currency_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// Binary to decimal chain
	bdtw_converter #(
		.DIGITS     (DIGITS),
		.VALUE_BITS (VALUE_BITS)
	) u_conv (
		.clk        (clk),
		.arst_n     (arst_n),
		.amt_valid  (amt_valid),
		.amt_stall  (amt_stall),
		.amt_word   (amt_word),
		.hand_valid (hand_valid),
		.hand_ready (hand_ready),
		.digits     (digits),
		.right_col  (right_col)
	);

	// Tile write sequencer
	bdtw_emitter #(
		.DIGITS (DIGITS)
	) u_emit (
		.clk             (clk),
		.arst_n          (arst_n),
		.hand_valid      (hand_valid),
		.hand_ready      (hand_ready),
		.digits          (digits),
		.right_col       (right_col),
		.digit_zero_tile (digit_zero_q),
		.currency_tile   (currency_q),
		.tile_valid      (tile_valid),
		.tile_stall      (tile_stall),
		.tile_word       (tile_word)
	);

endmodule

FILE: rtl/bdtw_digit_cell.sv
module bdtw_digit_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       clear,
	input  logic       shift_en,
	input  logic       bit_in,
	output logic       bit_out,
	output logic [3:0] digit
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	// Add 3 when the digit would reach 10 or more after doubling
	always_comb begin
		adj = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
	end

	assign bit_out = adj[3];
	assign digit   = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= 4'd0;
		end else if (clear) begin
			digit_q <= 4'd0;
		end else if (shift_en) begin
			digit_q <= {adj[2:0], bit_in};
		end
	end

	// A decimal cell never holds a code above nine
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		digit_q <= 4'd9)
		else $error("digit cell holds a non-decimal code");

endmodule

FILE: rtl/bdtw_converter.sv
module bdtw_converter #(
	parameter int unsigned DIGITS     = 9,
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        amt_valid,
	output logic                        amt_stall,
	input  bdtw_pkg::in_word_t          amt_word,
	output logic                        hand_valid,
	input  logic                        hand_ready,
	output logic [DIGITS-1:0][3:0]      digits,
	output logic [7:0]                  right_col
);

	localparam int unsigned CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

	bdtw_pkg::conv_state_t state_q, state_d;
	logic [VALUE_BITS-1:0] amt_q;
	logic [CW-1:0]         cnt_q;
	logic [7:0]            right_q;
	logic                  load;
	logic                  shift;
	logic [DIGITS-1:0]     carry;

	// Sequencer: load, shift VALUE_BITS times, hold until the emitter takes the digits
	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		shift   = 1'b0;
		case (state_q)
			bdtw_pkg::CV_IDLE: begin
				if (amt_valid) begin
					load    = 1'b1;
					state_d = bdtw_pkg::CV_SHIFT;
				end
			end
			bdtw_pkg::CV_SHIFT: begin
				shift = 1'b1;
				if (cnt_q == '0) begin
					state_d = bdtw_pkg::CV_DONE;
				end
			end
			bdtw_pkg::CV_DONE: begin
				if (hand_ready) begin
					if (amt_valid) begin
						load    = 1'b1;
						state_d = bdtw_pkg::CV_SHIFT;
					end else begin
						state_d = bdtw_pkg::CV_IDLE;
					end
				end
			end
			default: begin
				state_d = bdtw_pkg::CV_IDLE;
			end
		endcase
	end

	assign amt_stall  = !((state_q == bdtw_pkg::CV_IDLE) ||
	                      ((state_q == bdtw_pkg::CV_DONE) && hand_ready));
	assign hand_valid = (state_q == bdtw_pkg::CV_DONE);
	assign right_col  = right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdtw_pkg::CV_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				cnt_q <= CW'(VALUE_BITS - 1);
			end else if (shift) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Binary value shifts out MSB first into the digit chain
	always_ff @(posedge clk) begin
		if (load) begin
			amt_q   <= amt_word.amount[VALUE_BITS-1:0];
			right_q <= amt_word.right_column;
		end else if (shift) begin
			amt_q <= amt_q << 1;
		end
	end

	// Chain of decimal cells, units digit first; the top carry is dropped
	assign carry[0] = amt_q[VALUE_BITS-1];

	for (genvar i = 0; i < DIGITS; i++) begin : g_cell
		if (i < DIGITS - 1) begin : g_mid
			bdtw_digit_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.clear    (load),
				.shift_en (shift),
				.bit_in   (carry[i]),
				.bit_out  (carry[i+1]),
				.digit    (digits[i])
			);
		end else begin : g_top
			bdtw_digit_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.clear    (load),
				.shift_en (shift),
				.bit_in   (carry[i]),
				.bit_out  (),
				.digit    (digits[i])
			);
		end
	end

	// Shifting never falls back to idle without handing over the digits
	a_shift_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bdtw_pkg::CV_SHIFT) |=> (state_q != bdtw_pkg::CV_IDLE))
		else $error("conversion dropped before handoff");

endmodule

FILE: rtl/bdtw_emitter.sv
module bdtw_emitter #(
	parameter int unsigned DIGITS = 9
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   hand_valid,
	output logic                   hand_ready,
	input  logic [DIGITS-1:0][3:0] digits,
	input  logic [7:0]             right_col,
	input  logic [7:0]             digit_zero_tile,
	input  logic [7:0]             currency_tile,
	output logic                   tile_valid,
	input  logic                   tile_stall,
	output bdtw_pkg::out_word_t    tile_word
);

	localparam int unsigned PW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	bdtw_pkg::emit_state_t state_q, state_d;
	logic [DIGITS-1:0][3:0] dig_q;
	logic [7:0]             right_q;
	logic [PW-1:0]          pos_q;
	logic [PW-1:0]          top;
	logic                   any_nz;
	logic                   out_valid_q;
	bdtw_pkg::out_word_t    out_q;
	bdtw_pkg::out_word_t    word_d;
	logic                   out_free;
	logic                   gen;
	logic                   step;
	logic                   take;
	logic [3:0]             cur_digit;
	logic [7:0]             col;

	// Most significant non-zero digit of the incoming set
	always_comb begin
		top    = '0;
		any_nz = 1'b0;
		for (int p = 0; p < DIGITS; p++) begin
			if (digits[p] != 4'd0) begin
				top    = PW'(p);
				any_nz = 1'b1;
			end
		end
	end

	assign out_free  = !out_valid_q || !tile_stall;
	assign cur_digit = dig_q[pos_q];
	assign col       = right_q - 8'(pos_q);

	// Sequencer: currency tile, then digits from the top position down to units; an all-zero set writes nothing
	always_comb begin
		state_d    = state_q;
		hand_ready = 1'b0;
		gen        = 1'b0;
		step       = 1'b0;
		word_d     = out_q;
		case (state_q)
			bdtw_pkg::EM_IDLE: begin
				hand_ready = 1'b1;
			end
			bdtw_pkg::EM_CUR: begin
				if (out_free) begin
					gen                = 1'b1;
					word_d.tile_column = col - 8'd1;
					word_d.tile_code   = currency_tile;
					word_d.is_last     = 1'b0;
					state_d            = bdtw_pkg::EM_DIG;
				end
			end
			bdtw_pkg::EM_DIG: begin
				if (out_free) begin
					gen                = 1'b1;
					word_d.tile_column = col;
					word_d.tile_code   = digit_zero_tile + {4'd0, cur_digit};
					word_d.is_last     = (pos_q == '0);
					if (pos_q == '0) begin
						hand_ready = 1'b1;
						state_d    = bdtw_pkg::EM_IDLE;
					end else begin
						step = 1'b1;
					end
				end
			end
			default: begin
				state_d = bdtw_pkg::EM_IDLE;
			end
		endcase
		take = hand_ready && hand_valid;
		if (take) begin
			state_d = any_nz ? bdtw_pkg::EM_CUR : bdtw_pkg::EM_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bdtw_pkg::EM_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (gen) begin
				out_valid_q <= 1'b1;
			end else if (!tile_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Digit set, position and output word
	always_ff @(posedge clk) begin
		if (take) begin
			dig_q   <= digits;
			right_q <= right_col;
			pos_q   <= top;
		end else if (step) begin
			pos_q <= pos_q - PW'(1);
		end
		if (gen) begin
			out_q <= word_d;
		end
	end

	assign tile_valid = out_valid_q;
	assign tile_word  = out_q;

	// The currency tile is drawn only left of a non-zero leading digit
	a_lead_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bdtw_pkg::EM_CUR) |-> (cur_digit != 4'd0))
		else $error("leading digit is zero");

	// Leaving the digit run means the units word was just produced
	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == bdtw_pkg::EM_DIG) && (state_d != bdtw_pkg::EM_DIG)) |=>
		(out_valid_q && out_q.is_last))
		else $error("digit run ended without a last word");

endmodule

FILE: sim/tb_binary_to_decimal_tile_writer.sv
`timescale 1ns / 100ps

module tb_binary_to_decimal_tile_writer;

	localparam int unsigned DIGITS       = 9;
	localparam int unsigned DRAIN_CYCLES = 60;
	localparam int unsigned QUIET_LIMIT  = 4000;
	localparam int unsigned MAX_WAIT     = 14;

	// Expected tile writes, built from each accepted amount word
	class tile_scoreboard;
		bdtw_pkg::out_word_t pending[$];
		logic [7:0]          zero_tile;
		logic [7:0]          currency;
		int                  errors;
		int                  amounts;
		int                  tiles;

		function new();
			zero_tile = 8'd0;
			currency  = 8'd0;
			errors    = 0;
			amounts   = 0;
			tiles     = 0;
		endfunction

		// Split the amount into decimal digits and queue the writes it causes
		function void note_amount(bdtw_pkg::in_word_t w);
			int unsigned         rest;
			logic [3:0]          digit [DIGITS];
			int                  top;
			logic [7:0]          offset;
			bdtw_pkg::out_word_t t;
			rest = w.amount;
			top  = -1;
			for (int p = 0; p < DIGITS; p++) begin
				digit[p] = 4'(rest % 10);
				rest     = rest / 10;
				if (digit[p] != 4'd0) begin
					top = p;
				end
			end
			amounts++;
			// all shown digits zero: nothing is drawn
			if (top < 0) begin
				return;
			end
			offset        = 8'(top + 1);
			t.tile_column = w.right_column - offset;
			t.tile_code   = currency;
			t.is_last     = 1'b0;
			pending.push_back(t);
			for (int p = top; p >= 0; p--) begin
				offset        = 8'(p);
				t.tile_column = w.right_column - offset;
				t.tile_code   = zero_tile + {4'd0, digit[p]};
				t.is_last     = (p == 0);
				pending.push_back(t);
			end
		endfunction

		// Compare one accepted tile write with the oldest expectation
		function void check_tile(bdtw_pkg::out_word_t got);
			bdtw_pkg::out_word_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected tile write: expected none, %s %0d code %0d last %0b",
					$time, "got column", got.tile_column, got.tile_code, got.is_last);
				return;
			end
			want = pending.pop_front();
			tiles++;
			if (got.tile_column !== want.tile_column) begin
				errors++;
				$display("%0t: tile_column mismatch: expected %0d, got %0d",
					$time, want.tile_column, got.tile_column);
			end
			if (got.tile_code !== want.tile_code) begin
				errors++;
				$display("%0t: tile_code mismatch: expected %0d, got %0d",
					$time, want.tile_code, got.tile_code);
			end
			if (got.is_last !== want.is_last) begin
				errors++;
				$display("%0t: is_last mismatch: expected %0b, got %0b",
					$time, want.is_last, got.is_last);
			end
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        amt_valid;
	logic                        amt_stall;
	bdtw_pkg::in_word_t          amt_word;
	logic                        tile_valid;
	logic                        tile_stall;
	bdtw_pkg::out_word_t         tile_word;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [bdtw_pkg::ADDR_W-1:0] paddr;
	logic [31:0]                 pwdata;
	logic [31:0]                 prdata;
	logic                        pready;

	logic                        tx_burst;
	logic                        rx_burst;
	int                          settings;
	tile_scoreboard              sb = new();

	binary_to_decimal_tile_writer i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.amt_valid  (amt_valid),
		.amt_stall  (amt_stall),
		.amt_word   (amt_word),
		.tile_valid (tile_valid),
		.tile_stall (tile_stall),
		.tile_word  (tile_word),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Monitor both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (amt_valid && !amt_stall) begin
				sb.note_amount(amt_word);
			end
			if (tile_valid === 1'b1 && tile_stall === 1'b0) begin
				sb.check_tile(tile_word);
			end
		end
	end

	// Tile sink: random stall before taking each word, none in burst phases
	initial begin : tile_sink
		int hold;
		tile_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
			repeat (hold) begin
				@(negedge clk);
				tile_stall <= 1'b1;
			end
			@(negedge clk);
			tile_stall <= 1'b0;
			@(posedge clk);
			while (tile_valid !== 1'b1) begin
				@(posedge clk);
			end
		end
	end

	// Watchdog: ends the run after a long stretch with no handshake
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((amt_valid && !amt_stall) || (tile_valid && !tile_stall) ||
				(psel && penable && pready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("tb: failure");
		$finish;
	end

	// Send one amount word after a random gap, none in burst phases
	task automatic send_amount(input logic [31:0] amount, input logic [7:0] column);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
		repeat (gap) begin
			@(negedge clk);
			amt_valid <= 1'b0;
		end
		@(negedge clk);
		amt_valid <= 1'b1;
		amt_word  <= '{amount: amount, right_column: column};
		@(posedge clk);
		while (amt_stall) begin
			@(posedge clk);
		end
	endtask

	// Stop sending and wait until every expected tile write has come
	task automatic drain();
		@(negedge clk);
		amt_valid <= 1'b0;
		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write, then read back
	task automatic write_reg(input logic [bdtw_pkg::REG_IDX_W-1:0] idx,
		input logic [7:0] value);
		logic [31:0] data;
		data      = $urandom();
		data[7:0] = value;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= bdtw_pkg::ADDR_W'({idx, 2'b00});
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		if (idx == bdtw_pkg::REG_DIGIT_ZERO) begin
			sb.zero_tile = value;
		end else begin
			sb.currency = value;
		end
		settings++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		if (prdata[7:0] !== value) begin
			sb.errors++;
			$display("%0t: register %0d readback mismatch: expected %0d, got %0d",
				$time, idx, value, prdata[7:0]);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Random amount: full range, a given digit count, near multiples of 10^9,
	// or digits with many inner zeros
	function automatic logic [31:0] pick_amount();
		int unsigned lim;
		logic [31:0] v;
		case ($urandom_range(0, 3))
			0: begin
				v = $urandom();
			end
			1: begin
				lim = 1;
				repeat ($urandom_range(1, DIGITS)) lim = lim * 10;
				v = $urandom_range(0, lim - 1);
			end
			2: begin
				v = $urandom_range(0, 4) * 32'd1000000000 + $urandom_range(0, 999);
			end
			default: begin
				v = 32'd0;
				repeat (DIGITS) v = v * 10 + ($urandom_range(0, 1) ? $urandom_range(0, 9) : 0);
			end
		endcase
		return v;
	endfunction

	initial begin : stimulus
		logic [31:0] dir_amount [12];
		logic [7:0]  dir_column [12];
		logic [7:0]  zero_pick;
		logic [7:0]  cur_pick;

		arst_n    = 1'b0;
		amt_valid = 1'b0;
		amt_word  = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = 32'd0;
		tx_burst  = 1'b0;
		rx_burst  = 1'b0;
		settings  = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset register values: zero, multiples of 10^9,
		// overflow, column wrap, single and full-width digit counts
		dir_amount = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd1000000000, 32'd4000000000,
			32'hFFFFFFFF, 32'd999999999, 32'd123456789, 32'd100000000,
			32'd1000000001, 32'h80000000};
		dir_column = '{8'd10, 8'd0, 8'd255, 8'd1, 8'd20, 8'd20,
			8'd255, 8'd4, 8'd0, 8'd8, 8'd128, 8'd200};
		for (int k = 0; k < 12; k++) begin
			send_amount(dir_amount[k], dir_column[k]);
		end
		drain();

		// Code wrap on the digit tiles
		write_reg(bdtw_pkg::REG_DIGIT_ZERO, 8'd250);
		write_reg(bdtw_pkg::REG_CURRENCY, 8'd171);
		send_amount(32'd987654321, 8'd3);
		send_amount(32'd5, 8'd0);
		send_amount(32'hFFFFFFFF, 8'd7);
		send_amount(32'd3000000305, 8'd255);
		send_amount(32'd0, 8'd0);
		drain();

		// Random phases with varied register settings
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					zero_pick = 8'd0;
					cur_pick  = 8'd255;
				end
				1: begin
					zero_pick = 8'd255;
					cur_pick  = 8'd0;
				end
				default: begin
					zero_pick = $urandom_range(0, 255);
					cur_pick  = $urandom_range(0, 255);
				end
			endcase
			write_reg(bdtw_pkg::REG_DIGIT_ZERO, zero_pick);
			write_reg(bdtw_pkg::REG_CURRENCY, cur_pick);
			tx_burst = (phase == 3);
			rx_burst = (phase == 2) || (phase == 3);
			for (int k = 0; k < 27; k++) begin
				// hold off the sender until the block has emptied
				if (k == 14) begin
					drain();
				end
				send_amount(pick_amount(), 8'($urandom_range(0, 255)));
			end
			drain();
			tx_burst = 1'b0;
			rx_burst = 1'b0;
		end

		$display("run covered %0d amount words and %0d tile writes over %0d register writes",
			sb.amounts, sb.tiles, settings);
		$display("including zero, overflowing, column-wrap and code-wrap amounts");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/bdtw_pkg.sv
rtl/bdtw_digit_cell.sv
rtl/bdtw_converter.sv
rtl/bdtw_emitter.sv
rtl/binary_to_decimal_tile_writer.sv
sim/tb_binary_to_decimal_tile_writer.sv
